// ===== rtl/core/imu_pp_pkg.sv =====
`timescale 1ns / 1ps

package imu_pp_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PAYLOAD_BYTES = 8;
  localparam int unsigned PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_BYTES);
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned REG_IDX_W     = 2;

  // Packet kinds as they leave on the result port.
  localparam logic [KIND_W-1:0] KIND_ACCEL    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RATE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ATTITUDE = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_HEADER   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RATE     = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ATTITUDE = 2'd3;

  localparam logic [BYTE_W-1:0] HEADER_RST   = 8'd85;
  localparam logic [BYTE_W-1:0] ACCEL_RST    = 8'd81;
  localparam logic [BYTE_W-1:0] RATE_RST     = 8'd82;
  localparam logic [BYTE_W-1:0] ATTITUDE_RST = 8'd83;

  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] accel;
    logic [BYTE_W-1:0] rate;
    logic [BYTE_W-1:0] attitude;
  } cfg_codes_t;

  // One checked packet; payload byte 0 sits in the lowest bits.
  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] payload;
  } packet_t;

endpackage

// ===== rtl/core/imu_pp_front.sv =====
`timescale 1ns / 1ps

module imu_pp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         byte_valid,
  input  logic [imu_pp_pkg::BYTE_W-1:0] rx_byte,
  input  imu_pp_pkg::cfg_codes_t       codes,
  output logic                         pkt_valid,
  output imu_pp_pkg::packet_t          pkt
);
  import imu_pp_pkg::*;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_TYPE,
    ST_DATA,
    ST_CHECK
  } state_t;

  state_t               state_r, state_nxt;
  logic [BYTE_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [KIND_W-1:0]    kind_r, kind_nxt;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;

  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    kind_nxt    = kind_r;
    payload_nxt = payload_r;
    pkt_valid   = 1'b0;
    if (byte_valid) begin
      unique case (state_r)
        ST_HUNT: begin
          if (rx_byte == codes.header) begin
            sum_nxt   = rx_byte;
            count_nxt = '0;
            state_nxt = ST_TYPE;
          end
        end
        ST_TYPE: begin
          // A rejected type byte is not reconsidered as a header.
          state_nxt = ST_HUNT;
          if (rx_byte == codes.accel) begin
            kind_nxt  = KIND_ACCEL;
            state_nxt = ST_DATA;
          end else if (rx_byte == codes.rate) begin
            kind_nxt  = KIND_RATE;
            state_nxt = ST_DATA;
          end else if (rx_byte == codes.attitude) begin
            kind_nxt  = KIND_ATTITUDE;
            state_nxt = ST_DATA;
          end
          if (state_nxt == ST_DATA) begin
            sum_nxt = sum_r + rx_byte;
          end
        end
        ST_DATA: begin
          payload_nxt = {rx_byte, payload_r[PAYLOAD_W-1:BYTE_W]};
          sum_nxt     = sum_r + rx_byte;
          count_nxt   = count_r + 1'b1;
          if (count_r == CNT_W'(PAYLOAD_BYTES - 1)) begin
            state_nxt = ST_CHECK;
          end
        end
        ST_CHECK: begin
          pkt_valid = (sum_r == rx_byte);
          state_nxt = ST_HUNT;
        end
        default: state_nxt = ST_HUNT;
      endcase
    end
  end

  assign pkt.kind    = kind_r;
  assign pkt.payload = payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      sum_r   <= '0;
      count_r <= '0;
      kind_r  <= KIND_ACCEL;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

  a_check_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_valid && state_r == ST_CHECK) |=> (state_r == ST_HUNT))
    else $error("front did not return to hunting after the checksum byte");

  a_pkt_only_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    pkt_valid |-> (state_r == ST_CHECK && count_r == '0))
    else $error("packet issued outside the checksum phase");

endmodule

// ===== rtl/core/imu_pp_fifo.sv =====
`timescale 1ns / 1ps

module imu_pp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  imu_pp_pkg::packet_t wr_data,
  output logic                full,
  input  logic                rd_en,
  output logic                empty,
  output imu_pp_pkg::packet_t rd_data
);
  import imu_pp_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  packet_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]     count_r, count_nxt;

  assign full    = (count_r == (PTR_W+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && full))
    else $error("packet written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && empty))
    else $error("packet read from an empty queue");

endmodule

// ===== rtl/core/imu_pp_back.sv =====
`timescale 1ns / 1ps

module imu_pp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                pkt_avail,
  input  imu_pp_pkg::packet_t                 pkt,
  output logic                                pkt_take,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [imu_pp_pkg::KIND_W-1:0]       packet_kind,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] value_a,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] value_b,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] value_c,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] value_d
);
  import imu_pp_pkg::*;

  logic                      valid_r;
  logic [KIND_W-1:0]         kind_r;
  logic signed [VALUE_W-1:0] a_r, b_r, c_r, d_r;

  // The result register reloads whenever it is free or being emptied.
  assign pkt_take  = pkt_avail && (!valid_r || out_pop);
  assign out_empty = !valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pkt_take) begin
      valid_r <= 1'b1;
    end else if (out_pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_take) begin
      kind_r <= pkt.kind;
      a_r    <= $signed(pkt.payload[1*VALUE_W-1:0*VALUE_W]);
      b_r    <= $signed(pkt.payload[2*VALUE_W-1:1*VALUE_W]);
      c_r    <= $signed(pkt.payload[3*VALUE_W-1:2*VALUE_W]);
      d_r    <= $signed(pkt.payload[4*VALUE_W-1:3*VALUE_W]);
    end
  end

  assign packet_kind = kind_r;
  assign value_a     = a_r;
  assign value_b     = b_r;
  assign value_c     = c_r;
  assign value_d     = d_r;

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (kind_r == KIND_ACCEL || kind_r == KIND_RATE || kind_r == KIND_ATTITUDE))
    else $error("result carries an unknown packet kind");

endmodule

// ===== rtl/core/imu_serial_packet_parser_core.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                           Handshake
// input     in_rx_byte                                      in_push / in_full
// result    out_packet_kind, out_value_a .. out_value_d     out_empty / out_pop
// config    cfg_index, cfg_data                             cfg_we
//
// One byte is taken every cycle while in_full is low; the parser state machine
// sees each byte once. A packet whose checksum matches is written into the queue
// when its checksum byte is accepted, and the result register loads it from the
// queue once that register is free; it then appears on the result ports.
// in_full rises only when that queue holds two packets, so a slow reader stalls input.
// rst_n is synchronous and active low; it restores the register defaults and hunting.

module imu_serial_packet_parser_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic [imu_pp_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [imu_pp_pkg::KIND_W-1:0]         out_packet_kind,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] out_value_a,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] out_value_b,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] out_value_c,
  output logic signed [imu_pp_pkg::VALUE_W-1:0] out_value_d,
  input  logic                                  cfg_we,
  input  logic [imu_pp_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [imu_pp_pkg::BYTE_W-1:0]         cfg_data
);
  import imu_pp_pkg::*;

  cfg_codes_t codes_r;
  logic       byte_accept;
  logic       front_pkt_valid;
  packet_t    front_pkt;
  logic       q_empty;
  logic       q_take;
  packet_t    q_pkt;

  // The configuration registers hold the header and the three type codes.
  // A write lands on the next edge; there is no read-back path.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.header   <= HEADER_RST;
      codes_r.accel    <= ACCEL_RST;
      codes_r.rate     <= RATE_RST;
      codes_r.attitude <= ATTITUDE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEADER:   codes_r.header   <= cfg_data;
        REG_ACCEL:    codes_r.accel    <= cfg_data;
        REG_RATE:     codes_r.rate     <= cfg_data;
        REG_ATTITUDE: codes_r.attitude <= cfg_data;
        default: ;
      endcase
    end
  end

  // A request is taken whenever the queue has room, since any byte may be
  // the checksum byte that completes a packet.
  assign byte_accept = in_push && !in_full;

  imu_pp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_accept),
    .rx_byte    (in_rx_byte),
    .codes      (codes_r),
    .pkt_valid  (front_pkt_valid),
    .pkt        (front_pkt)
  );

  // The queue decouples packet detection from result delivery.
  imu_pp_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_pkt_valid),
    .wr_data (front_pkt),
    .full    (in_full),
    .rd_en   (q_take),
    .empty   (q_empty),
    .rd_data (q_pkt)
  );

  // The back end splits the payload into four little-endian words.
  imu_pp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pkt_avail   (!q_empty),
    .pkt         (q_pkt),
    .pkt_take    (q_take),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .packet_kind (out_packet_kind),
    .value_a     (out_value_a),
    .value_b     (out_value_b),
    .value_c     (out_value_c),
    .value_d     (out_value_d)
  );

  a_full_blocks_packets: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |-> !front_pkt_valid)
    else $error("packet completed while the queue was full");

endmodule
